@@ hw/rtl/uid_allowlist_table_core_macros.svh @@
// Assertion macros shared by the allowlist table RTL.
// Used by files that check their own sequencing; expects clk and rst in scope.
`ifndef UID_ALLOWLIST_TABLE_CORE_MACROS_SVH
`define UID_ALLOWLIST_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define UAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/uat_pkg.sv @@
// Shared types and codes for the identifier allowlist table.
// No dependencies; used by the sequencer, output stage and top level.
package uat_pkg;

  localparam int OP_W   = 2;
  localparam int ID_W   = 32;
  localparam int ST_W   = 2;
  localparam int USED_W = 5;

  // Operation codes; the unused code behaves as a check.
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_PRESENT = 2'd2;
  localparam logic [ST_W-1:0] ST_ABSENT  = 2'd3;

  typedef struct packed {
    logic [USED_W-1:0] entries_used;
    logic [ST_W-1:0]   status;
    logic              found;
  } result_t;

endpackage

@@ hw/rtl/uid_allowlist_table_core.sv @@
// Top level of the identifier allowlist table: storage, sequencer, output stage.
// Depends on uat_pkg, uat_ram, uat_seq and uat_outreg.
//
//  Channel  | Dir | Payload                                        | Meaning
//  ---------+-----+------------------------------------------------+--------------------
//  s_axis   | in  | tdata[1:0] op, [33:2] card_id, [39:34] zero    | one table operation
//  m_axis   | out | tdata[0] found, [2:1] status, [7:3] entries    | one result per item
//
// An item is searched by the one comparator, which visits n entries, where n is the
// match position plus one, or the count on a miss; its result then goes to the output register.
// A successful remove then moves the entries above the removed one down by one place
// through the storage's write and read ports; no entry moves when the last is removed.
// Reset (rst, synchronous) empties the table by clearing the count; no clearing pass.
// A stalled output holds one result in its register; one more item is taken, then input waits.

module uid_allowlist_table_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [1:0] op, [33:2] card_id, [39:34] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // [0] found, [2:1] status, [7:3] entries_used
);

  // Address width covers the entries; count width also holds the full depth.
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [uat_pkg::ID_W-1:0]       mem_wdata;
  logic                           mem_re;
  logic [AW-1:0]                  mem_raddr;
  logic [uat_pkg::ID_W-1:0]       mem_rdata;
  logic                           res_valid;
  logic                           res_ready;
  uat_pkg::result_t               res;

  uat_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (uat_pkg::ID_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The sequencer owns the count and steps the comparator over the stored entries.
  uat_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tdata[1:0]),
    .in_key    (s_axis_tdata[33:2]),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The result register decouples the sequencer from a stalled consumer.
  uat_outreg u_outreg (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ hw/rtl/uat_ram.sv @@
// Identifier storage: one write port and one read port with registered data.
// No package dependency; instantiated by the top level.
module uat_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/uat_seq.sv @@
// Sequencer for the allowlist table: linear search with one shared comparator,
// append on add and shift-down on remove. Depends on uat_pkg and the macros.
`include "uid_allowlist_table_core_macros.svh"

module uat_seq #(
  parameter int TABLE_DEPTH = 16,
  parameter int AW = 4,
  parameter int CW = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [uat_pkg::OP_W-1:0]    in_op,
  input  logic [uat_pkg::ID_W-1:0]    in_key,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [uat_pkg::ID_W-1:0]    mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  input  logic [uat_pkg::ID_W-1:0]    mem_rdata,
  output logic                        res_valid,
  input  logic                        res_ready,
  output uat_pkg::result_t            res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_SHIFT,
    S_RESULT
  } state_t;

  state_t                    state;
  logic [uat_pkg::OP_W-1:0]  op;
  logic [uat_pkg::ID_W-1:0]  key;
  logic [CW-1:0]             count;
  logic [CW-1:0]             rd_idx;
  logic                      cmp_v;
  logic [AW-1:0]             cmp_idx;
  logic                      hit;
  logic [AW-1:0]             pos;
  logic [CW-1:0]             sh_rd;
  logic                      wr_v;
  logic [AW-1:0]             wr_addr;
  logic [uat_pkg::ST_W-1:0]  status;

  logic match;
  logic full;

  // The one comparator, fed by the registered read of the entry under test.
  assign match = cmp_v && (mem_rdata == key);
  assign full  = (count == CW'(TABLE_DEPTH));

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_RESULT);
  assign res.found        = hit;
  assign res.status       = status;
  assign res.entries_used = uat_pkg::USED_W'(count);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = key;
    mem_re    = 1'b0;
    mem_raddr = rd_idx[AW-1:0];
    unique case (state)
      S_SEARCH: begin
        mem_re = !match && (rd_idx != count);
      end
      S_DECIDE: begin
        mem_we = (op == uat_pkg::OP_ADD) && !full && !hit;
      end
      S_SHIFT: begin
        mem_we    = wr_v;
        mem_waddr = wr_addr;
        mem_wdata = mem_rdata;
        mem_re    = (sh_rd != count);
        mem_raddr = sh_rd[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      cmp_v <= 1'b0;
      wr_v  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op     <= in_op;
            key    <= in_key;
            rd_idx <= '0;
            cmp_v  <= 1'b0;
            state  <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (match) begin
            hit   <= 1'b1;
            pos   <= cmp_idx;
            cmp_v <= 1'b0;
            state <= S_DECIDE;
          end else if (rd_idx == count) begin
            hit   <= 1'b0;
            cmp_v <= 1'b0;
            state <= S_DECIDE;
          end else begin
            cmp_v   <= 1'b1;
            cmp_idx <= rd_idx[AW-1:0];
            rd_idx  <= rd_idx + CW'(1);
          end
        end
        S_DECIDE: begin
          case (op)
            uat_pkg::OP_ADD: begin
              state <= S_RESULT;
              if (full) begin
                status <= uat_pkg::ST_FULL;
              end else if (hit) begin
                status <= uat_pkg::ST_PRESENT;
              end else begin
                count  <= count + CW'(1);
                status <= uat_pkg::ST_DONE;
              end
            end
            uat_pkg::OP_REMOVE: begin
              if (hit) begin
                sh_rd <= CW'(pos) + CW'(1);
                wr_v  <= 1'b0;
                state <= S_SHIFT;
              end else begin
                status <= uat_pkg::ST_ABSENT;
                state  <= S_RESULT;
              end
            end
            default: begin
              status <= hit ? uat_pkg::ST_DONE : uat_pkg::ST_ABSENT;
              state  <= S_RESULT;
            end
          endcase
        end
        S_SHIFT: begin
          if (sh_rd != count) begin
            wr_v    <= 1'b1;
            wr_addr <= AW'(sh_rd - CW'(1));
            sh_rd   <= sh_rd + CW'(1);
          end else begin
            wr_v <= 1'b0;
            if (!wr_v) begin
              count  <= count - CW'(1);
              status <= uat_pkg::ST_DONE;
              state  <= S_RESULT;
            end
          end
        end
        S_RESULT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `UAT_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(TABLE_DEPTH), "count above table depth")
  `UAT_ASSERT_NOW(a_no_write_search, state == S_IDLE || state == S_SEARCH, !mem_we, "write during search")
  `UAT_ASSERT_NEXT(a_search_holds_count, state == S_SEARCH, count == $past(count), "count moved in search")
  `UAT_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == S_SEARCH, "accepted item not searched")

endmodule

@@ hw/rtl/uat_outreg.sv @@
// Output register for result items, so a waiting result does not hold back input.
// Depends on uat_pkg for the result type.
module uat_outreg (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  output logic             res_ready,
  input  uat_pkg::result_t res,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata
);

  uat_pkg::result_t held;

  assign res_ready    = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
      if (res_valid) begin
        held <= res;
      end
    end
  end

endmodule
